// ===== hw/rtl/mre_pkg.sv =====
// Shared types and constants of the monochrome raster engine.
package mre_pkg;

   localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;

   localparam logic [2:0] MODE_READ   = 3'd0;
   localparam logic [2:0] MODE_BITMAP = 3'd1;
   localparam logic [2:0] MODE_HLINE  = 3'd2;
   localparam logic [2:0] MODE_VLINE  = 3'd3;
   localparam logic [2:0] MODE_RECT   = 3'd4;
   localparam logic [2:0] MODE_CLEAR  = 3'd5;
   localparam logic [2:0] MODE_SCREEN = 3'd6;

   localparam logic [2:0] RECT_TOP    = 3'd0;
   localparam logic [2:0] RECT_BOTTOM = 3'd1;
   localparam logic [2:0] RECT_LEFT   = 3'd2;
   localparam logic [2:0] RECT_RIGHT  = 3'd3;
   localparam logic [2:0] RECT_FILL   = 3'd4;

   localparam logic [1:0] PSIZE_8  = 2'd0;
   localparam logic [1:0] PSIZE_16 = 2'd1;

   typedef enum logic [5:0] {
      ST_SWEEP = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_JOB   = 6'b000100,
      ST_RD    = 6'b001000,
      ST_WR    = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

endpackage

// ===== hw/rtl/mre_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mre_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8000,
   parameter int AW    = 13
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hw/rtl/monochrome_raster_engine.sv =====
// Top level of the monochrome raster engine: command sequencer and frame store.
//
// Usage:
//   One command word enters on the req_ channel (mode in req_tuser, operands in
//   req_tdata); exactly one result word leaves on the rsp_ channel with the read
//   data and an out-of-store status flag. Commands are worked one at a time:
//   req_tready is high only while the sequencer is idle.
//   Every drawing or clearing command walks the touched frame-store words with
//   a read-modify-write through one RAM port pair; a word outside the store
//   is skipped. Each span (a rectangle has up to five spans) gets a setup
//   step, and the result is handed over once the last span is done.
//   The work for a long line or area scales with the words it covers.
//   Clear screen sweeps the whole store, one word per cycle.
//   After reset the same sweep runs to zero the store before the first command
//   is accepted; no result is produced for it.
//   The result sits in an output register: a stalled receiver does not stop the
//   next command from being accepted and worked, only its hand-over waits until
//   the held result word has been taken.
module monochrome_raster_engine #(
   parameter int ROW_WORDS = 20,
   parameter int ROW_COUNT = 400
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [10:0] x_first, [21:11] x_second, [31:22] y_first, [41:32] y_second,
   // [51:42] rect_width, [60:52] rect_height, [61] fill_on, [93:62] pattern,
   // [95:94] pattern_size, [108:96] word_address, [111:109] zero
   input  logic [111:0] req_tdata,
   // [2:0] mode
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] read_data, [32] status, [39:33] zero
   output logic [39:0]  rsp_tdata
);
   import mre_pkg::*;

   localparam int STORE = ROW_WORDS * ROW_COUNT;
   localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;
   localparam int SAW   = $clog2(1024 * ROW_WORDS + 64) + 2;
   localparam logic signed [SAW-1:0] STORE_S = SAW'(STORE);
   localparam logic signed [SAW-1:0] ROWW_S  = SAW'(ROW_WORDS);

   state_type state_ff, state_in;

   // captured command
   logic [2:0]         mode_ff;
   logic signed [10:0] xa_ff, xb_ff;
   logic signed [9:0]  ya_ff, yb_ff;
   logic [9:0]         rw_ff;
   logic [8:0]         rh_ff;
   logic               fill_ff;
   logic [31:0]        pat_ff;
   logic [1:0]         psize_ff;
   logic [12:0]        waddr_ff;
   logic [2:0]         phase_ff, phase_in;

   // active span
   logic signed [6:0]     w_ff, w_in, w1_ff, w2_ff;
   logic signed [10:0]    row_ff, row_in, yhi_ff;
   logic signed [SAW-1:0] base_ff, base_in;
   logic [31:0]           m1_ff, m2_ff;
   logic                  raw_ff, clr_ff, rdo_ff, rdo_in;
   logic [AW-1:0]         addr_ff, addr_in;

   logic          fault_ff, fault_in;
   logic [31:0]   data_ff, data_in;
   logic          resp_ff, resp_in;
   logic [AW-1:0] sweep_ff, sweep_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_data_ff;
   logic          rsp_status_ff;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [31:0]   ram_wdata, ram_rdata;

   logic accept;
   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // ---------------- span decode ----------------
   logic signed [11:0] xa_w, xb_w, xmin, xmax, xr_rect;
   logic signed [10:0] ya_w, yb_w, ymin, ymax, y2_rect;
   logic               job_ok, job_raw, job_clr, job_more;
   logic signed [11:0] job_xl, job_xr;
   logic signed [10:0] job_ylo, job_yhi;
   logic signed [6:0]  job_w1, job_w2;
   logic [31:0]        job_m1, job_m2, aligned;
   logic [63:0]        wide;
   logic [5:0]         pwidth;
   logic               spill;
   logic signed [SAW-1:0] ylo_ext, job_base;

   assign xa_w    = 12'(xa_ff);
   assign xb_w    = 12'(xb_ff);
   assign ya_w    = 11'(ya_ff);
   assign yb_w    = 11'(yb_ff);
   assign xmin    = (xa_w > xb_w) ? xb_w : xa_w;
   assign xmax    = (xa_w > xb_w) ? xa_w : xb_w;
   assign ymin    = (ya_w > yb_w) ? yb_w : ya_w;
   assign ymax    = (ya_w > yb_w) ? ya_w : yb_w;
   assign xr_rect = xa_w + $signed({2'b00, rw_ff});
   assign y2_rect = ya_w + $signed({2'b00, rh_ff});

   always_comb begin
      job_ok  = 1'b1;
      job_raw = 1'b0;
      job_clr = 1'b0;
      job_xl  = xa_w;
      job_xr  = xa_w;
      job_ylo = ya_w;
      job_yhi = ya_w;
      case (mode_ff)
         MODE_BITMAP: begin
            job_ok  = !ya_ff[9];
            job_raw = 1'b1;
         end
         MODE_HLINE: begin
            job_xl = xmin;
            job_xr = xmax;
         end
         MODE_VLINE: begin
            job_ylo = ymin;
            job_yhi = ymax;
         end
         MODE_RECT: begin
            case (phase_ff)
               RECT_TOP: begin
                  job_ok = (rw_ff != 10'd0);
                  job_xr = xr_rect;
               end
               RECT_BOTTOM: begin
                  job_ok  = (rw_ff != 10'd0);
                  job_xr  = xr_rect;
                  job_ylo = y2_rect;
                  job_yhi = y2_rect;
               end
               RECT_LEFT: begin
                  job_ok  = (rh_ff != 9'd0);
                  job_yhi = y2_rect;
               end
               RECT_RIGHT: begin
                  job_ok  = (rh_ff != 9'd0);
                  job_xl  = xr_rect;
                  job_xr  = xr_rect;
                  job_yhi = y2_rect;
               end
               default: begin
                  job_xr  = xr_rect;
                  job_ylo = ya_w + 11'sd1;
                  job_yhi = y2_rect - 11'sd1;
                  job_ok  = fill_ff && (job_ylo <= job_yhi);
               end
            endcase
         end
         MODE_CLEAR: begin
            job_clr = 1'b1;
            job_xl  = xmin;
            job_xr  = xmax;
            job_ylo = ymin[10] ? 11'sd0 : ymin;
            job_yhi = ymax - 11'sd1;
            job_ok  = (yb_ff > 10'sd0) && !xb_ff[10] && (job_ylo <= job_yhi);
         end
         default: begin
            job_ok = 1'b0;
         end
      endcase
   end

   assign job_more = (mode_ff == MODE_RECT) && (phase_ff != RECT_FILL);

   // bitmap: align the used bits at the top, then shift right by the pixel offset
   always_comb begin
      case (psize_ff)
         PSIZE_8:  begin aligned = {pat_ff[7:0], 24'd0};  pwidth = 6'd8;  end
         PSIZE_16: begin aligned = {pat_ff[15:0], 16'd0}; pwidth = 6'd16; end
         default:  begin aligned = pat_ff;                pwidth = 6'd32; end
      endcase
   end
   assign wide  = {aligned, 32'd0} >> xa_ff[4:0];
   assign spill = ({1'b0, xa_ff[4:0]} + pwidth) > 6'd32;

   assign job_w1 = 7'(job_xl >>> 5);
   assign job_w2 = job_raw ? (job_w1 + 7'(spill)) : 7'(job_xr >>> 5);
   assign job_m1 = job_raw ? wide[63:32] : (WORD_ONES >> job_xl[4:0]);
   assign job_m2 = job_raw ? wide[31:0]  : (WORD_ONES << (5'd31 - job_xr[4:0]));

   assign ylo_ext  = SAW'(job_ylo);
   assign job_base = ylo_ext * ROWW_S;

   // ---------------- word walk ----------------
   logic signed [SAW-1:0] cur_addr;
   logic                  cur_ok;
   logic [31:0]           set_mask;

   assign cur_addr = base_ff + SAW'(w_ff);
   assign cur_ok   = !cur_addr[SAW-1] && (cur_addr < STORE_S);

   always_comb begin
      if (raw_ff) begin
         set_mask = (w_ff == w1_ff) ? m1_ff : m2_ff;
      end else begin
         set_mask = ((w_ff == w1_ff) ? m1_ff : WORD_ONES) &
                    ((w_ff == w2_ff) ? m2_ff : WORD_ONES);
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      w_in      = w_ff;
      row_in    = row_ff;
      base_in   = base_ff;
      addr_in   = addr_ff;
      rdo_in    = rdo_ff;
      fault_in  = fault_ff;
      data_in   = data_ff;
      resp_in   = resp_ff;
      sweep_in  = sweep_ff;
      ram_we    = 1'b0;
      ram_waddr = addr_ff;
      ram_wdata = clr_ff ? (ram_rdata & ~set_mask) : (ram_rdata | set_mask);
      ram_raddr = cur_addr[AW-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         ST_SWEEP: begin
            ram_we    = 1'b1;
            ram_waddr = sweep_ff;
            ram_wdata = '0;
            sweep_in  = sweep_ff + AW'(1);
            if (sweep_ff == AW'(STORE - 1)) begin
               state_in = resp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_JOB;
               phase_in = RECT_TOP;
               fault_in = 1'b0;
               data_in  = '0;
               rdo_in   = 1'b0;
            end
         end
         ST_JOB: begin
            case (mode_ff)
               MODE_READ: begin
                  ram_raddr = AW'(waddr_ff);
                  if (32'(waddr_ff) < 32'(STORE)) begin
                     rdo_in   = 1'b1;
                     state_in = ST_WR;
                  end else begin
                     fault_in = 1'b1;
                     state_in = ST_DONE;
                  end
               end
               MODE_SCREEN: begin
                  sweep_in = '0;
                  resp_in  = 1'b1;
                  state_in = ST_SWEEP;
               end
               MODE_BITMAP, MODE_HLINE, MODE_VLINE, MODE_RECT, MODE_CLEAR: begin
                  if (job_ok) begin
                     w_in     = job_w1;
                     row_in   = job_ylo;
                     base_in  = job_base;
                     state_in = ST_RD;
                  end else if (job_more) begin
                     phase_in = phase_ff + 3'd1;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_RD, ST_WR: begin
            if (state_ff == ST_WR && rdo_ff) begin
               data_in  = ram_rdata;
               state_in = ST_DONE;
            end else begin
               if (state_ff == ST_RD) begin
                  addr_in = cur_addr[AW-1:0];
                  if (cur_ok) begin
                     state_in = ST_WR;
                  end else begin
                     fault_in = 1'b1;
                  end
               end else begin
                  ram_we = 1'b1;
               end
               // advance when the word is written or skipped
               if (state_ff == ST_WR || !cur_ok) begin
                  if (w_ff != w2_ff) begin
                     w_in     = w_ff + 7'sd1;
                     state_in = ST_RD;
                  end else if (row_ff != yhi_ff) begin
                     w_in     = w1_ff;
                     row_in   = row_ff + 11'sd1;
                     base_in  = base_ff + ROWW_S;
                     state_in = ST_RD;
                  end else if (job_more) begin
                     phase_in = phase_ff + 3'd1;
                     state_in = ST_JOB;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               resp_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         resp_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= RECT_TOP;
         rdo_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         resp_ff      <= resp_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         rdo_ff       <= rdo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_tuser;
         xa_ff    <= req_tdata[10:0];
         xb_ff    <= req_tdata[21:11];
         ya_ff    <= req_tdata[31:22];
         yb_ff    <= req_tdata[41:32];
         rw_ff    <= req_tdata[51:42];
         rh_ff    <= req_tdata[60:52];
         fill_ff  <= req_tdata[61];
         pat_ff   <= req_tdata[93:62];
         psize_ff <= req_tdata[95:94];
         waddr_ff <= req_tdata[108:96];
      end
      if (state_ff == ST_JOB) begin
         w1_ff  <= job_w1;
         w2_ff  <= job_w2;
         yhi_ff <= job_yhi;
         m1_ff  <= job_m1;
         m2_ff  <= job_m2;
         raw_ff <= job_raw;
         clr_ff <= job_clr;
      end
      w_ff     <= w_in;
      row_ff   <= row_in;
      base_ff  <= base_in;
      addr_ff  <= addr_in;
      fault_ff <= fault_in;
      data_ff  <= data_in;
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff   <= data_ff;
         rsp_status_ff <= fault_ff;
      end
   end

   mre_ram #(
      .WIDTH (32),
      .DEPTH (STORE),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_status_ff, rsp_data_ff};

   // store writes happen only in the sweep or the write half of a word update
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_WR || state_ff == ST_SWEEP))
      else $error("frame store written outside sweep or write step");

   a_accept_job: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_JOB))
      else $error("accepted command did not start decode");

   a_wr_after_rd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR) |-> ($past(state_ff) == ST_RD || $past(state_ff) == ST_JOB))
      else $error("write step without preceding read");

   a_result_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) |=>
         (rsp_tvalid && state_ff == ST_IDLE))
      else $error("result hand-over lost");

endmodule

// ===== bench/monochrome_raster_engine_tb.sv =====
// Self-checking testbench of the monochrome raster engine against a shadow frame store.
module monochrome_raster_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mre_pkg::*;

   localparam int ROW_WORDS   = 20;
   localparam int ROW_COUNT   = 400;
   localparam int STORE_WORDS = ROW_WORDS * ROW_COUNT;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam logic [2:0] MODE_SPARE = 3'd7;

   typedef struct {
      logic [2:0]        mode;
      logic signed [10:0] xa;
      logic signed [10:0] xb;
      logic signed [9:0]  ya;
      logic signed [9:0]  yb;
      logic [9:0]        rw;
      logic [8:0]        rh;
      logic              fill;
      logic [31:0]       pat;
      logic [1:0]        psize;
      logic [12:0]       addr;
   } command_type;

   typedef struct {
      logic [31:0] data;
      logic        status;
   } outcome_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [111:0] req_tdata;
   logic [2:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [39:0]  rsp_tdata;

   logic [31:0] shadow_store [STORE_WORDS];
   bit          out_of_store;
   outcome_type pending_outcomes [$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          quiet = 0;
   bit          long_hold = 0;

   monochrome_raster_engine #(.ROW_WORDS(ROW_WORDS), .ROW_COUNT(ROW_COUNT)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------- shadow frame store ----------------
   function automatic void merge_word(longint a, logic [31:0] m, bit clear);
      if (a < 0 || a >= STORE_WORDS) begin
         out_of_store = 1;
         return;
      end
      if (clear) shadow_store[a] &= m;
      else       shadow_store[a] |= m;
   endfunction

   function automatic void paint_hline(longint x1, longint x2, longint y);
      longint t, w1, w2, base;
      logic [31:0] m1, m2;
      if (x1 > x2) begin t = x1; x1 = x2; x2 = t; end
      w1 = x1 >>> 5;
      w2 = x2 >>> 5;
      m1 = 32'hFFFF_FFFF >> (x1 & 31);
      m2 = 32'hFFFF_FFFF << (31 - (x2 & 31));
      base = y * ROW_WORDS;
      if (w1 == w2) begin
         merge_word(base + w1, m1 & m2, 1'b0);
         return;
      end
      merge_word(base + w1, m1, 1'b0);
      for (longint i = w1 + 1; i < w2; i++) merge_word(base + i, 32'hFFFF_FFFF, 1'b0);
      merge_word(base + w2, m2, 1'b0);
   endfunction

   function automatic void paint_vline(longint x, longint y1, longint y2);
      longint t, w;
      logic [31:0] m;
      w = x >>> 5;
      m = 32'h1 << (31 - (x & 31));
      if (y1 > y2) begin t = y1; y1 = y2; y2 = t; end
      for (longint y = y1; y <= y2; y++) merge_word(y * ROW_WORDS + w, m, 1'b0);
   endfunction

   function automatic void paint_bitmap(logic [31:0] pat, logic [1:0] psize, longint x, longint y);
      int          w, off;
      logic [63:0] bits, wide;
      longint      a;
      w = (psize == PSIZE_8) ? 8 : (psize == PSIZE_16) ? 16 : 32;
      off = int'(x & 31);
      bits = {32'd0, pat} & ((64'd1 << w) - 64'd1);
      wide = (bits << (64 - w)) >> off;
      if (y < 0) return;
      a = y * ROW_WORDS + (x >>> 5);
      merge_word(a, wide[63:32], 1'b0);
      if (off + w > 32) merge_word(a + 1, wide[31:0], 1'b0);
   endfunction

   function automatic void paint_rect(longint x, longint y, longint w, longint h, bit fill);
      longint x2, y2;
      x2 = x + w;
      y2 = y + h;
      if (w > 0) begin
         paint_hline(x, x2, y);
         paint_hline(x, x2, y2);
      end
      if (h > 0) begin
         paint_vline(x, y, y2);
         paint_vline(x2, y, y2);
      end
      if (fill)
         for (longint r = y + 1; r < y2; r++) paint_hline(x, x2, r);
   endfunction

   function automatic void erase_area(longint x1, longint x2, longint y1, longint y2);
      longint t, w1, w2, base;
      logic [31:0] k1, k2;
      if (y2 <= 0 || x2 < 0) return;
      if (x1 > x2) begin t = x1; x1 = x2; x2 = t; end
      if (y1 > y2) begin t = y1; y1 = y2; y2 = t; end
      if (y1 < 0) y1 = 0;
      w1 = x1 >>> 5;
      w2 = x2 >>> 5;
      k1 = ~(32'hFFFF_FFFF >> (x1 & 31));
      k2 = ~(32'hFFFF_FFFF << (31 - (x2 & 31)));
      for (longint y = y1; y < y2; y++) begin
         base = y * ROW_WORDS;
         if (w1 == w2) begin
            merge_word(base + w1, k1 | k2, 1'b1);
         end else begin
            merge_word(base + w1, k1, 1'b1);
            for (longint i = w1 + 1; i < w2; i++) merge_word(base + i, 32'd0, 1'b1);
            merge_word(base + w2, k2, 1'b1);
         end
      end
   endfunction

   // Apply one command to the shadow store and return the word it must produce.
   function automatic outcome_type execute_command(command_type c);
      outcome_type o;
      o.data = 32'd0;
      out_of_store = 0;
      case (c.mode)
         MODE_READ: begin
            if (c.addr < STORE_WORDS) o.data = shadow_store[c.addr];
            else out_of_store = 1;
         end
         MODE_BITMAP: paint_bitmap(c.pat, c.psize, longint'(c.xa), longint'(c.ya));
         MODE_HLINE:  paint_hline(longint'(c.xa), longint'(c.xb), longint'(c.ya));
         MODE_VLINE:  paint_vline(longint'(c.xa), longint'(c.ya), longint'(c.yb));
         MODE_RECT:   paint_rect(longint'(c.xa), longint'(c.ya), longint'(c.rw),
                                 longint'(c.rh), c.fill);
         MODE_CLEAR:  erase_area(longint'(c.xa), longint'(c.xb), longint'(c.ya),
                                 longint'(c.yb));
         MODE_SCREEN: foreach (shadow_store[i]) shadow_store[i] = 32'd0;
         default: ;
      endcase
      o.status = out_of_store;
      return o;
   endfunction

   // ---------------- checking ----------------
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata[31:0], 32'd0);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_tdata[31:0] !== want.data)
               report_mismatch("read_data", rsp_tdata[31:0], want.data);
            if (rsp_tdata[32] !== want.status)
               report_mismatch("status", {31'd0, rsp_tdata[32]}, {31'd0, want.status});
            if (rsp_tdata[39:33] !== 7'd0)
               report_mismatch("pad bits", {25'd0, rsp_tdata[39:33]}, 32'd0);
         end
      end
   end

   // Receiver: random stall bursts, one long hold on request, none when quiet.
   initial begin
      rsp_tready = 0;
      forever begin
         if (long_hold) begin
            rsp_tready <= 0;
            repeat (400) @(posedge clock);
            long_hold = 0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_tready <= 1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // ---------------- stimulus ----------------
   // Offer a word, hold it until taken; valid stays high unless a random gap follows.
   task automatic send_command(command_type c);
      req_tvalid <= 1;
      req_tuser  <= c.mode;
      req_tdata  <= {3'd0, c.addr, c.psize, c.pat, c.fill, c.rh, c.rw,
                     c.yb, c.ya, c.xb, c.xa};
      do @(posedge clock); while (!req_tready);
      pending_outcomes.push_back(execute_command(c));
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   function automatic command_type make_command(logic [2:0] mode, int xa, int xb, int ya,
                                                int yb, int rw, int rh, bit fill,
                                                logic [31:0] pat, int psize, int addr);
      command_type c;
      c.mode = mode; c.xa = 11'(xa); c.xb = 11'(xb); c.ya = 10'(ya); c.yb = 10'(yb);
      c.rw = 10'(rw); c.rh = 9'(rh); c.fill = fill; c.pat = pat; c.psize = 2'(psize);
      c.addr = 13'(addr);
      return c;
   endfunction

   function automatic command_type random_command(bit wild);
      command_type c;
      int          pick;
      c.mode = 3'($urandom_range(0, 7));
      c.xa = 11'($urandom); c.xb = 11'($urandom); c.ya = 10'($urandom); c.yb = 10'($urandom);
      c.rw = 10'($urandom); c.rh = 9'($urandom); c.fill = 1'($urandom); c.pat = $urandom;
      c.psize = 2'($urandom); c.addr = 13'($urandom);
      if (wild) begin
         // keep the costly walks bounded: whole-screen wipes rare, fills short
         if (c.mode == MODE_SCREEN && $urandom_range(0, 3) != 0) c.mode = MODE_READ;
         if (c.mode == MODE_RECT && c.fill) c.rh[8:5] = 4'd0;
         if (c.mode == MODE_CLEAR) c.ya = 10'(c.yb - 10'($urandom_range(0, 6)));
         return c;
      end
      pick = $urandom_range(0, 99);
      c.mode = (pick < 28) ? MODE_READ  : (pick < 48) ? MODE_BITMAP :
               (pick < 63) ? MODE_HLINE : (pick < 73) ? MODE_VLINE  :
               (pick < 86) ? MODE_RECT  : (pick < 97) ? MODE_CLEAR  :
               (pick < 98) ? MODE_SCREEN : MODE_SPARE;
      c.xa = 11'($urandom_range(0, 639));
      c.ya = 10'($urandom_range(0, 399));
      c.xb = 11'(int'(c.xa) + int'($urandom_range(0, 200)) - 100);
      c.yb = 10'(int'(c.ya) + int'($urandom_range(0, 40)) - 20);
      c.rw = 10'($urandom_range(0, 80));
      c.rh = 9'($urandom_range(0, 30));
      c.psize = 2'($urandom_range(0, 3));
      // aim reads at words that were probably drawn
      if ($urandom_range(0, 1) != 0)
         c.addr = 13'(int'(c.ya) * ROW_WORDS + int'(c.xa >>> 5));
      else
         c.addr = 13'($urandom_range(0, STORE_WORDS - 1));
      return c;
   endfunction

   task automatic test_directed();
      send_command(make_command(MODE_READ,   0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_command(make_command(MODE_READ,   0, 0, 0, 0, 0, 0, 0, 0, 0, 8191));
      send_command(make_command(MODE_BITMAP, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 2, 0));
      send_command(make_command(MODE_BITMAP, 30, 0, 1, 0, 0, 0, 0, 32'h1234_A5A5, 1, 0));
      send_command(make_command(MODE_BITMAP, -1024, 0, 0, 0, 0, 0, 0, 32'hF00F_0FF0, 3, 0));
      send_command(make_command(MODE_BITMAP, 8, 0, -1, 0, 0, 0, 0, 32'hFFFF_FFFF, 2, 0));
      send_command(make_command(MODE_BITMAP, 1023, 0, 511, 0, 0, 0, 0, 32'h0000_00C3, 0, 0));
      send_command(make_command(MODE_READ,   0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      send_command(make_command(MODE_READ,   0, 0, 0, 0, 0, 0, 0, 0, 0, 21));
      send_command(make_command(MODE_HLINE,  40, 5, 2, 0, 0, 0, 0, 0, 0, 0));
      send_command(make_command(MODE_HLINE,  -1024, 1023, -512, 0, 0, 0, 0, 0, 0, 0));
      send_command(make_command(MODE_VLINE,  100, 0, 10, 3, 0, 0, 0, 0, 0, 0));
      send_command(make_command(MODE_VLINE,  -1, 0, -512, 511, 0, 0, 0, 0, 0, 0));
      send_command(make_command(MODE_RECT,   5, 0, 5, 0, 0, 0, 1, 0, 0, 0));
      send_command(make_command(MODE_RECT,   10, 0, 10, 0, 1023, 511, 0, 0, 0, 0));
      send_command(make_command(MODE_RECT,   50, 0, 50, 0, 40, 20, 1, 0, 0, 0));
      send_command(make_command(MODE_READ,   0, 0, 0, 0, 0, 0, 0, 0, 0, 60 * ROW_WORDS + 2));
      send_command(make_command(MODE_CLEAR,  0, 100, 0, 0, 0, 0, 0, 0, 0, 0));
      send_command(make_command(MODE_CLEAR,  0, -1, 0, 50, 0, 0, 0, 0, 0, 0));
      send_command(make_command(MODE_CLEAR,  60, 10, 30, 2, 0, 0, 0, 0, 0, 0));
      send_command(make_command(MODE_READ,   0, 0, 0, 0, 0, 0, 0, 0, 0, 2 * ROW_WORDS));
      send_command(make_command(MODE_CLEAR,  -1024, 1023, -512, 511, 0, 0, 0, 0, 0, 0));
      send_command(make_command(MODE_SPARE,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_command(make_command(MODE_SCREEN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_command(make_command(MODE_READ,   0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++)
         send_command(random_command($urandom_range(0, 99) < 4));
   endtask

   // Hold the receiver off while commands keep coming, so the input stalls.
   task automatic test_backpressure();
      long_hold = 1;
      quiet = 1;
      for (int i = 0; i < 12; i++) send_command(random_command(1'b0));
      quiet = 0;
   endtask

   // Pause the sender until every outstanding word has come back.
   task automatic test_drain_pause();
      req_tvalid <= 0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   initial begin
      reset      = 1;
      req_tvalid = 0;
      req_tdata  = '0;
      req_tuser  = '0;
      foreach (shadow_store[i]) shadow_store[i] = 32'd0;
      repeat (8) @(posedge clock);
      reset <= 0;

      test_directed();
      test_random(800);
      test_backpressure();
      test_drain_pause();
      test_random(780);
      quiet = 1;
      test_random(200);

      req_tvalid <= 0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/mre_pkg.sv
hw/rtl/mre_ram.sv
hw/rtl/monochrome_raster_engine.sv
bench/monochrome_raster_engine_tb.sv
